>>> rtl/jdc_pkg.sv
// shared types and constants for the julian day / calendar converter
// no dependencies; imported by every module of the block
package jdc_pkg;

  // register levels from an accepted beat to the data out of the compute modules
  localparam int unsigned PIPE_DEPTH = 7;

  localparam logic [22:0] JDN_MAX      = 23'd5373484;
  localparam logic [16:0] SEC_MAX      = 17'd86399;
  localparam logic [17:0] HALF_DAY     = 18'd43200;
  localparam logic [17:0] SECS_PER_DAY = 18'd86400;

  localparam logic ACT_TO_DAY  = 1'b0;
  localparam logic ACT_TO_DATE = 1'b1;

  typedef struct packed {
    logic [22:0]        jdn;
    logic signed [16:0] off;
  } fwd_res_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } hms_t;

  typedef struct packed {
    logic signed [14:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    hms_t               hms;
  } rev_res_t;

endpackage

>>> rtl/jdc_fwd.sv
// forward path: gregorian date and time of day to julian day number and noon offset
// seven register levels; uses jdc_pkg
module jdc_fwd (
  input  logic               clk,
  input  logic signed [14:0] year,
  input  logic [3:0]         month,
  input  logic [4:0]         day,
  input  logic [4:0]         hour,
  input  logic [5:0]         minute,
  input  logic [5:0]         second,
  output jdc_pkg::fwd_res_t  res
);
  import jdc_pkg::*;

  // reciprocal of 100, exact for magnitudes below 2^15
  localparam int unsigned SE = 21;
  localparam logic [14:0] KE = 15'(((64'd1 << SE) + 64'd99) / 64'd100);

  // 367 * (shifted month) / 12, indexed by the raw month code
  function automatic logic [8:0] month_days(input logic [3:0] mo);
    logic [8:0] r;
    unique case (mo)
      4'd0:    r = 9'd305;
      4'd1:    r = 9'd336;
      4'd2:    r = 9'd367;
      4'd3:    r = 9'd30;
      4'd4:    r = 9'd61;
      4'd5:    r = 9'd91;
      4'd6:    r = 9'd122;
      4'd7:    r = 9'd152;
      4'd8:    r = 9'd183;
      4'd9:    r = 9'd214;
      4'd10:   r = 9'd244;
      4'd11:   r = 9'd275;
      4'd12:   r = 9'd305;
      4'd13:   r = 9'd336;
      4'd14:   r = 9'd367;
      default: r = 9'd397;
    endcase
    return r;
  endfunction

  // stage 1
  logic signed [15:0] y1_s1, y2_s1;
  logic [8:0]         ct_s1;
  logic [4:0]         dy_s1;
  logic signed [17:0] off_s1;
  // stage 2
  logic signed [25:0] b_s2;
  logic [7:0]         eq_s2;
  logic               eneg_s2;
  logic [8:0]         ct_s2;
  logic [4:0]         dy_s2;
  logic signed [16:0] off_s2;
  // stage 3
  logic signed [23:0] b4_s3;
  logic signed [10:0] e3_s3;
  logic [8:0]         ct_s3;
  logic [4:0]         dy_s3;
  logic signed [16:0] off_s3;
  // stage 4
  logic signed [25:0] sum_s4;
  logic signed [16:0] off_s4;
  // stages 5 to 7
  fwd_res_t           res_s5, res_s6, res_s7;

  logic signed [15:0] y1;
  logic [16:0]        tsum;
  logic [14:0]        mag;
  logic [29:0]        eprod;
  logic signed [8:0]  e_s;
  logic signed [8:0]  e34;
  logic signed [25:0] sum;

  always_comb begin
    // january and february count as months of the previous year
    y1    = $signed({year[14], year}) + 16'sd4800 - ((month <= 4'd2) ? 16'sd1 : 16'sd0);
    tsum  = 17'(hour) * 17'd3600 + 17'(minute) * 17'd60 + 17'(second);
    mag   = y2_s1[15] ? 15'(-y2_s1) : y2_s1[14:0];
    eprod = 30'(mag) * 30'(KE);
    e_s   = eneg_s2 ? -$signed({1'b0, eq_s2}) : $signed({1'b0, eq_s2});
    e34   = 9'((e3_s3 + ((e3_s3 < 0) ? 11'sd3 : 11'sd0)) >>> 2);
    sum   = 26'(b4_s3) + $signed({17'd0, ct_s3}) + $signed({21'd0, dy_s3})
            - 26'(e34) - 26'sd32075;
  end

  always_ff @(posedge clk) begin
    y1_s1   <= y1;
    y2_s1   <= y1 + 16'sd100;
    ct_s1   <= month_days(month);
    dy_s1   <= day;
    off_s1  <= $signed({1'b0, tsum}) - 18'sd43200;

    b_s2    <= 26'(y1_s1) * 26'sd1461;
    eq_s2   <= eprod[SE+7:SE];
    eneg_s2 <= y2_s1[15];
    ct_s2   <= ct_s1;
    dy_s2   <= dy_s1;
    if (off_s1 < -18'sd43200) begin
      off_s2 <= -17'sd43200;
    end else if (off_s1 > 18'sd43199) begin
      off_s2 <= 17'sd43199;
    end else begin
      off_s2 <= off_s1[16:0];
    end

    // divisions truncate toward zero
    b4_s3   <= 24'((b_s2 + ((b_s2 < 0) ? 26'sd3 : 26'sd0)) >>> 2);
    e3_s3   <= 11'(e_s) * 11'sd3;
    ct_s3   <= ct_s2;
    dy_s3   <= dy_s2;
    off_s3  <= off_s2;

    sum_s4  <= sum;
    off_s4  <= off_s3;

    if (sum_s4 < 0) begin
      res_s5.jdn <= '0;
    end else if (sum_s4 > $signed({3'd0, JDN_MAX})) begin
      res_s5.jdn <= JDN_MAX;
    end else begin
      res_s5.jdn <= sum_s4[22:0];
    end
    res_s5.off <= off_s4;
    res_s6     <= res_s5;
    res_s7     <= res_s6;
  end

  assign res = res_s7;

endmodule

>>> rtl/jdc_hms.sv
// time of day in seconds to hour, minute and second by reciprocal multiplies
// six register levels; uses jdc_pkg
module jdc_hms (
  input  logic              clk,
  input  logic [16:0]       tod,
  output jdc_pkg::hms_t     hms
);
  import jdc_pkg::*;

  localparam int unsigned HMS_LAT = PIPE_DEPTH - 1;
  localparam int unsigned NDLY    = HMS_LAT - 2;
  localparam int unsigned SH = 29;
  localparam int unsigned SM = 23;
  localparam logic [17:0] KH = 18'(((64'd1 << SH) + 64'd3599) / 64'd3600);
  localparam logic [17:0] KM = 18'(((64'd1 << SM) + 64'd59) / 64'd60);

  logic [34:0] hprod, mprod;
  logic [4:0]  hour_s1;
  logic [10:0] totm_s1;
  logic [16:0] tod_s1;
  hms_t        dly [NDLY+1];

  always_comb begin
    hprod = 35'(tod) * 35'(KH);
    mprod = 35'(tod) * 35'(KM);
  end

  always_ff @(posedge clk) begin
    hour_s1        <= hprod[SH+4:SH];
    totm_s1        <= mprod[SM+10:SM];
    tod_s1         <= tod;
    dly[0].hour    <= hour_s1;
    dly[0].minute  <= 6'(totm_s1 - 11'(hour_s1) * 11'd60);
    dly[0].second  <= 6'(tod_s1 - 17'(totm_s1) * 17'd60);
    for (int k = 1; k <= NDLY; k++) begin
      dly[k] <= dly[k-1];
    end
  end

  assign hms = dly[NDLY];

endmodule

>>> rtl/jdc_rev.sv
// reverse path: julian day number and seconds past noon to civil date and time
// seven register levels, time split in jdc_hms; uses jdc_pkg
module jdc_rev (
  input  logic              clk,
  input  logic [22:0]       day_number,
  input  logic [16:0]       seconds_past_noon,
  output jdc_pkg::rev_res_t res
);
  import jdc_pkg::*;

  // scaled reciprocals: floor(x*c/d) taken as (x*K) >> S, exact over the value range
  localparam int unsigned SN = 41;
  localparam int unsigned SI = 37;
  localparam int unsigned SJ = 22;
  localparam logic [25:0] KN = 26'(((64'd1 << SN) * 64'd4 + 64'd146096) / 64'd146097);
  localparam logic [28:0] KI = 29'(((64'd1 << SI) * 64'd4000 + 64'd1461000) / 64'd1461001);
  localparam logic [17:0] KJ = 18'(((64'd1 << SJ) * 64'd80 + 64'd2446) / 64'd2447);

  // 2447 * j / 80
  function automatic logic [8:0] day_base(input logic [3:0] j);
    logic [8:0] r;
    unique case (j)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd152;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd305;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd428;
      default: r = 9'd458;
    endcase
    return r;
  endfunction

  logic [22:0] jc;
  logic [16:0] sc;
  logic [17:0] tod0;
  logic        roll;
  logic [16:0] tod;
  logic [48:0] nprod;
  logic [24:0] cyc;
  logic [45:0] iprod;
  logic [27:0] jprod;
  logic        lf;
  logic [14:0] cent;

  logic [22:0] l_s1, l_s2;
  logic [16:0] tod_s1;
  logic [7:0]  n_s2, n_s3, n_s4, n_s5, n_s6;
  logic [15:0] l2_s3, l2_s4;
  logic [6:0]  i_s4, i_s5, i_s6;
  logic [9:0]  l3_s5, l3_s6;
  logic [3:0]  j_s6;
  logic signed [14:0] yy_s7;
  logic [3:0]  mm_s7;
  logic [4:0]  dd_s7;

  always_comb begin
    jc    = (day_number > JDN_MAX) ? JDN_MAX : day_number;
    sc    = (seconds_past_noon > SEC_MAX) ? SEC_MAX : seconds_past_noon;
    tod0  = {1'b0, sc} + HALF_DAY;
    // past midnight the date belongs to the next day number
    roll  = (tod0 >= SECS_PER_DAY);
    tod   = roll ? 17'(tod0 - SECS_PER_DAY) : tod0[16:0];
    nprod = 49'(l_s1) * 49'(KN);
    cyc   = (25'(n_s2) * 25'd146097 + 25'd3) >> 2;
    iprod = 46'({1'b0, l2_s3} + 17'd1) * 46'(KI);
    jprod = 28'(l3_s5) * 28'(KJ);
    lf    = (j_s6 >= 4'd11);
    cent  = 15'(($signed({7'd0, n_s6}) - 15'sd49) * 15'sd100);
  end

  always_ff @(posedge clk) begin
    l_s1   <= jc + 23'(roll) + 23'd68569;
    tod_s1 <= tod;

    n_s2   <= nprod[SN+7:SN];
    l_s2   <= l_s1;

    l2_s3  <= 16'(l_s2 - cyc[22:0]);
    n_s3   <= n_s2;

    i_s4   <= iprod[SI+6:SI];
    l2_s4  <= l2_s3;
    n_s4   <= n_s3;

    l3_s5  <= 10'(18'(l2_s4) + 18'd31 - ((18'(i_s4) * 18'd1461) >> 2));
    i_s5   <= i_s4;
    n_s5   <= n_s4;

    j_s6   <= jprod[SJ+3:SJ];
    l3_s6  <= l3_s5;
    i_s6   <= i_s5;
    n_s6   <= n_s5;

    dd_s7  <= 5'(l3_s6 - 10'(day_base(j_s6)));
    mm_s7  <= j_s6 + 4'd2 - (lf ? 4'd12 : 4'd0);
    yy_s7  <= $signed(cent) + $signed({8'd0, i_s6}) + $signed({14'd0, lf});
  end

  jdc_hms u_hms (
    .clk (clk),
    .tod (tod_s1),
    .hms (res.hms)
  );

  assign res.year  = yy_s7;
  assign res.month = mm_s7;
  assign res.day   = dd_s7;

endmodule

>>> rtl/julian_day_calendar_converter.sv
// top level of the julian day / calendar converter: valid pipeline and result register
// depends on jdc_pkg, jdc_fwd, jdc_rev (which holds jdc_hms)

// Converts one beat per clock in either direction between a proleptic gregorian
// date-time and a julian day number with whole seconds from noon. A beat is taken
// on every edge where start is high; busy is always low, so start may stay high
// for a new beat each cycle. The result is on the ports after the output register,
// marked by done for one cycle, and is taken at the edge that ends it: the block has
// no way to hold it. The result waits on the reverse conversion's chain of scaled
// reciprocal multiplies (day-number split into centuries, years, months, each with a
// register after the multiply) plus the output register. Fields of the direction not
// selected read as zero.
module julian_day_calendar_converter (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic               action,
  input  logic signed [14:0] year,
  input  logic [3:0]         month,
  input  logic [4:0]         day,
  input  logic [4:0]         hour,
  input  logic [5:0]         minute,
  input  logic [5:0]         second,
  input  logic [22:0]        day_number,
  input  logic [16:0]        seconds_past_noon,
  output logic [22:0]        out_day_number,
  output logic signed [16:0] seconds_from_noon,
  output logic signed [14:0] out_year,
  output logic [3:0]         out_month,
  output logic [4:0]         out_day,
  output logic [4:0]         out_hour,
  output logic [5:0]         out_minute,
  output logic [5:0]         out_second
);
  import jdc_pkg::*;

  localparam int unsigned LAT = PIPE_DEPTH + 1;

  logic                  accept;
  logic [PIPE_DEPTH-1:0] vld;
  logic [PIPE_DEPTH-1:0] act;
  fwd_res_t              fwd;
  rev_res_t              rev;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  jdc_fwd u_fwd (
    .clk    (clk),
    .year   (year),
    .month  (month),
    .day    (day),
    .hour   (hour),
    .minute (minute),
    .second (second),
    .res    (fwd)
  );

  jdc_rev u_rev (
    .clk               (clk),
    .day_number        (day_number),
    .seconds_past_noon (seconds_past_noon),
    .res               (rev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[PIPE_DEPTH-2:0], accept};
      done <= vld[PIPE_DEPTH-1];
    end
  end

  // direction bit rides along with each beat
  always_ff @(posedge clk) begin
    act <= {act[PIPE_DEPTH-2:0], action};
  end

  always_ff @(posedge clk) begin
    if (act[PIPE_DEPTH-1] == ACT_TO_DATE) begin
      out_day_number    <= '0;
      seconds_from_noon <= '0;
      out_year          <= rev.year;
      out_month         <= rev.month;
      out_day           <= rev.day;
      out_hour          <= rev.hms.hour;
      out_minute        <= rev.hms.minute;
      out_second        <= rev.hms.second;
    end else begin
      out_day_number    <= fwd.jdn;
      seconds_from_noon <= fwd.off;
      out_year          <= '0;
      out_month         <= '0;
      out_day           <= '0;
      out_hour          <= '0;
      out_minute        <= '0;
      out_second        <= '0;
    end
  end

`ifndef NO_ASSERTIONS
  a_beat_returns: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LAT done)
    else $error("accepted beat produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result without an accepted beat");

  a_date_excl: assert property (@(posedge clk) disable iff (rst)
    (done && out_month != 4'd0) |-> (out_day_number == '0 && seconds_from_noon == '0))
    else $error("date result carries day number fields");

  a_fwd_excl: assert property (@(posedge clk) disable iff (rst)
    (done && out_month == 4'd0) |->
      (out_year == '0 && out_day == '0 && out_hour == '0 && out_minute == '0 &&
       out_second == '0))
    else $error("day number result carries date fields");

  a_ranges: assert property (@(posedge clk) disable iff (rst)
    done |-> (out_day_number <= JDN_MAX && out_hour <= 5'd23 && out_minute <= 6'd59 &&
              out_second <= 6'd59 && out_month <= 4'd12))
    else $error("result field out of range");
`endif

endmodule

>>> tb/julian_day_calendar_converter_tb.sv
// self-checking testbench for julian_day_calendar_converter: directed calendar edges, then
// random conversions in both directions checked against an in-bench integer predictor
// depends on jdc_pkg and julian_day_calendar_converter
module julian_day_calendar_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jdc_pkg::*;

  localparam longint LAST_DAY = longint'(JDN_MAX);
  localparam longint LAST_SEC = longint'(SEC_MAX);
  localparam longint HALF     = longint'(HALF_DAY);
  localparam longint DAY_SECS = longint'(SECS_PER_DAY);
  localparam int     RANDOM_BEATS = 1900;

  typedef struct {
    logic               action;
    logic signed [14:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [22:0]        day_number;
    logic [16:0]        seconds_past_noon;
  } conv_req_t;

  typedef struct {
    logic [22:0]        day_number;
    logic signed [16:0] from_noon;
    logic signed [14:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
  } conv_res_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               action = ACT_TO_DAY;
  logic signed [14:0] year = '0;
  logic [3:0]         month = '0;
  logic [4:0]         day = '0;
  logic [4:0]         hour = '0;
  logic [5:0]         minute = '0;
  logic [5:0]         second = '0;
  logic [22:0]        day_number = '0;
  logic [16:0]        seconds_past_noon = '0;
  logic               busy;
  logic               done;
  logic [22:0]        out_day_number;
  logic signed [16:0] seconds_from_noon;
  logic signed [14:0] out_year;
  logic [3:0]         out_month;
  logic [4:0]         out_day;
  logic [4:0]         out_hour;
  logic [5:0]         out_minute;
  logic [5:0]         out_second;

  conv_res_t pending_conversions[$];
  int        mismatch_count = 0;
  bit        burst_mode = 1'b0;

  julian_day_calendar_converter u_dut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .done              (done),
    .action            (action),
    .year              (year),
    .month             (month),
    .day               (day),
    .hour              (hour),
    .minute            (minute),
    .second            (second),
    .day_number        (day_number),
    .seconds_past_noon (seconds_past_noon),
    .out_day_number    (out_day_number),
    .seconds_from_noon (seconds_from_noon),
    .out_year          (out_year),
    .out_month         (out_month),
    .out_day           (out_day),
    .out_hour          (out_hour),
    .out_minute        (out_minute),
    .out_second        (out_second)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // fliegel / van flandern in both directions; all longint so division truncates toward zero
  function automatic conv_res_t predict_conversion(conv_req_t r);
    conv_res_t p;
    longint yr, mo, dy, hr, mi, se, adj, jdn, off, tod, l, n, i, j, yy, mm, dd;
    p = '{default: '0};
    if (r.action == ACT_TO_DAY) begin
      yr = r.year;
      mo = r.month;
      dy = r.day;
      hr = r.hour;
      mi = r.minute;
      se = r.second;
      adj = (mo - 14) / 12;
      jdn = 1461 * (yr + 4800 + adj) / 4 + 367 * (mo - 2 - 12 * adj) / 12
            - (3 * ((yr + 4900 + adj) / 100)) / 4 + dy - 32075;
      off = (hr - 12) * 3600 + mi * 60 + se;
      if (jdn < 0) jdn = 0;
      if (jdn > LAST_DAY) jdn = LAST_DAY;
      if (off < -HALF) off = -HALF;
      if (off > HALF - 1) off = HALF - 1;
      p.day_number = jdn[22:0];
      p.from_noon  = off[16:0];
    end else begin
      jdn = r.day_number;
      tod = r.seconds_past_noon;
      if (jdn > LAST_DAY) jdn = LAST_DAY;
      if (tod > LAST_SEC) tod = LAST_SEC;
      tod = tod + HALF;
      // past midnight the civil date is the next day
      if (tod >= DAY_SECS) begin
        tod = tod - DAY_SECS;
        jdn = jdn + 1;
      end
      l  = jdn + 68569;
      n  = 4 * l / 146097;
      l  = l - (146097 * n + 3) / 4;
      i  = 4000 * (l + 1) / 1461001;
      l  = l - 1461 * i / 4 + 31;
      j  = 80 * l / 2447;
      dd = l - 2447 * j / 80;
      l  = j / 11;
      mm = j + 2 - 12 * l;
      yy = 100 * (n - 49) + i + l;
      p.year   = yy[14:0];
      p.month  = mm[3:0];
      p.day    = dd[4:0];
      p.hour   = 5'(tod / 3600);
      p.minute = 6'((tod % 3600) / 60);
      p.second = 6'(tod % 60);
    end
    return p;
  endfunction

  // fields of the unused direction get random bits, they must not matter
  function automatic conv_req_t day_request(int y, int m, int d, int h, int mi, int s);
    conv_req_t r;
    r.action            = ACT_TO_DAY;
    r.year              = 15'(y);
    r.month             = 4'(m);
    r.day               = 5'(d);
    r.hour              = 5'(h);
    r.minute            = 6'(mi);
    r.second            = 6'(s);
    r.day_number        = 23'($urandom);
    r.seconds_past_noon = 17'($urandom);
    return r;
  endfunction

  function automatic conv_req_t date_request(int unsigned jdn, int unsigned sp);
    conv_req_t r;
    r.action            = ACT_TO_DATE;
    r.year              = 15'($urandom);
    r.month             = 4'($urandom);
    r.day               = 5'($urandom);
    r.hour              = 5'($urandom);
    r.minute            = 6'($urandom);
    r.second            = 6'($urandom);
    r.day_number        = 23'(jdn);
    r.seconds_past_noon = 17'(sp);
    return r;
  endfunction

  function automatic conv_req_t random_request();
    conv_req_t r;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if ($urandom_range(0, 1)) begin
      r = day_request($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      if (pick >= 2) begin
        r.year   = 15'(int'($urandom_range(0, 14711)) - 4712);
        r.month  = 4'($urandom_range(1, 12));
        r.day    = 5'($urandom_range(1, 31));
        r.hour   = 5'($urandom_range(0, 23));
        r.minute = 6'($urandom_range(0, 59));
        r.second = 6'($urandom_range(0, 59));
      end
    end else begin
      r = date_request($urandom, $urandom);
      if (pick >= 2) begin
        r.seconds_past_noon = 17'($urandom_range(0, 86399));
        // lean on both ends of the day number range now and then
        case (pick)
          2:       r.day_number = 23'($urandom_range(0, 800));
          3:       r.day_number = 23'($urandom_range(5372684, 5373484));
          default: r.day_number = 23'($urandom_range(0, 5373484));
        endcase
      end
    end
    return r;
  endfunction

  task automatic send_conversion(conv_req_t r);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 12);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start             <= 1'b1;
    action            <= r.action;
    year              <= r.year;
    month             <= r.month;
    day               <= r.day;
    hour              <= r.hour;
    minute            <= r.minute;
    second            <= r.second;
    day_number        <= r.day_number;
    seconds_past_noon <= r.seconds_past_noon;
    do @(posedge clk); while (busy !== 1'b0);
    pending_conversions.push_back(predict_conversion(r));
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_conversions.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 3) @(posedge clk);
  endtask

  task automatic test_to_day_edges();
    send_conversion(day_request(-4712, 1, 1, 12, 0, 0));
    send_conversion(day_request(9999, 12, 31, 23, 59, 59));
    send_conversion(day_request(2000, 1, 1, 12, 0, 0));
    send_conversion(day_request(1582, 10, 15, 0, 0, 0));
    send_conversion(day_request(2000, 2, 29, 6, 30, 15));
    send_conversion(day_request(1900, 3, 1, 11, 59, 59));
    send_conversion(day_request(0, 3, 1, 18, 0, 1));
    drain_results();
  endtask

  task automatic test_to_day_out_of_range();
    send_conversion(day_request(2023, 0, 10, 12, 0, 0));
    send_conversion(day_request(2023, 15, 31, 12, 0, 0));
    send_conversion(day_request(2021, 2, 31, 0, 0, 0));
    send_conversion(day_request(2021, 6, 0, 12, 0, 0));
    send_conversion(day_request(-16384, 1, 1, 0, 0, 0));
    send_conversion(day_request(16383, 12, 31, 31, 63, 63));
    send_conversion(day_request(100, 7, 4, 0, 0, 0));
    drain_results();
  endtask

  task automatic test_to_date_edges();
    send_conversion(date_request(0, 0));
    send_conversion(date_request(0, 43199));
    send_conversion(date_request(0, 43200));
    send_conversion(date_request(0, 86399));
    send_conversion(date_request(2451545, 0));
    send_conversion(date_request(2299160, 50000));
    send_conversion(date_request(5373484, 43199));
    send_conversion(date_request(5373484, 43200));
    send_conversion(date_request(8388607, 131071));
    drain_results();
  endtask

  task automatic test_random_mix();
    for (int k = 0; k < RANDOM_BEATS; k++) begin
      if (k % 64 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      send_conversion(random_request());
    end
    burst_mode = 1'b0;
    drain_results();
  endtask

  task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    conv_res_t want;
    if (!rst && done === 1'b1) begin
      if (pending_conversions.size() == 0) begin
        $display("%0t: result beat with no conversion outstanding", $time);
        mismatch_count++;
      end else begin
        want = pending_conversions.pop_front();
        check_field("out_day_number", want.day_number, out_day_number);
        check_field("seconds_from_noon", want.from_noon, seconds_from_noon);
        check_field("out_year", want.year, out_year);
        check_field("out_month", want.month, out_month);
        check_field("out_day", want.day, out_day);
        check_field("out_hour", want.hour, out_hour);
        check_field("out_minute", want.minute, out_minute);
        check_field("out_second", want.second, out_second);
      end
    end
  end

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    test_to_day_edges();
    test_to_day_out_of_range();
    test_to_date_edges();
    test_random_mix();
    if (mismatch_count == 0 && pending_conversions.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
